// ----- hdl/crt_pkg.sv -----
// Shared types, constants and calendar helper functions for the RTC tick core.
package crt_pkg;

    // Stream widths (tdata padded to whole bytes)
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;

    // Counter limits
    localparam int TICKS_PER_SECOND_DEF = 1000;
    localparam int SEC_PER_MIN          = 60;
    localparam int MIN_PER_HOUR         = 60;
    localparam int HOUR_PER_DAY         = 24;
    localparam int MONTH_WRAP           = 13;
    localparam int YEAR_CENTURY         = 100;

    // Request commands
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SET_DT = 2'd1,
        CMD_SET_MS = 2'd2
    } cmd_t;

    // Values carried by set requests
    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [7:0] year;
        logic [9:0] millis;
    } set_t;

    // Calendar and uptime state
    typedef struct packed {
        logic [9:0]  millis;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [7:0]  year;
        logic [31:0] uptime;
    } cal_state_t;

    localparam cal_state_t CAL_RESET = '{
        millis: 10'd0,
        second: 6'd0,
        minute: 6'd0,
        hour:   5'd0,
        day:    5'd1,
        month:  4'd1,
        year:   8'd26,
        uptime: 32'd0
    };

    // Gregorian leap rule on the 8-bit year; the only multiple of 400 in range is zero
    function automatic logic is_leap(input logic [7:0] y);
        logic div4;
        logic century;
        logic quad_century;
        div4         = (y[1:0] == 2'b00);
        quad_century = (y == 8'd0);
        century      = quad_century || (y == 8'(YEAR_CENTURY)) || (y == 8'(2 * YEAR_CENTURY));
        return (div4 && !century) || quad_century;
    endfunction

    // Month length; months outside 1-12 use 31 days
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- hdl/crt_step.sv -----
// Next-state logic of the calendar: tick carry chain and set loads.
module crt_step #(
    parameter int TICKS_PER_SECOND = crt_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic [1:0]          cmd,
    input  crt_pkg::set_t       set_val,
    input  crt_pkg::cal_state_t cur,
    output crt_pkg::cal_state_t nxt
);

    localparam logic [10:0] TPS_LIM = 11'(TICKS_PER_SECOND);

    logic [10:0] ms_inc;
    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic [5:0]  day_inc;
    logic [4:0]  month_inc;
    logic [4:0]  day_len;
    logic        ms_wrap;
    logic        sec_wrap;
    logic        min_wrap;
    logic        hour_wrap;
    logic        day_wrap;
    logic        month_wrap;

    // Increment each counter and find its rollover
    assign ms_inc     = {1'b0, cur.millis} + 11'd1;
    assign sec_inc    = {1'b0, cur.second} + 7'd1;
    assign min_inc    = {1'b0, cur.minute} + 7'd1;
    assign hour_inc   = {1'b0, cur.hour} + 6'd1;
    assign day_inc    = {1'b0, cur.day} + 6'd1;
    assign month_inc  = {1'b0, cur.month} + 5'd1;
    assign day_len    = crt_pkg::month_len(cur.month, crt_pkg::is_leap(cur.year));

    assign ms_wrap    = (ms_inc >= TPS_LIM);
    assign sec_wrap   = (sec_inc >= 7'(crt_pkg::SEC_PER_MIN));
    assign min_wrap   = (min_inc >= 7'(crt_pkg::MIN_PER_HOUR));
    assign hour_wrap  = (hour_inc >= 6'(crt_pkg::HOUR_PER_DAY));
    assign day_wrap   = (day_inc > {1'b0, day_len});
    assign month_wrap = (month_inc >= 5'(crt_pkg::MONTH_WRAP));

    // Apply the request to the state
    always_comb
    begin
        nxt = cur;
        unique case (cmd)
            crt_pkg::CMD_TICK:
            begin
                nxt.uptime = cur.uptime + 32'd1;
                nxt.millis = ms_wrap ? 10'd0 : ms_inc[9:0];
                if (ms_wrap)
                begin
                    nxt.second = sec_wrap ? 6'd0 : sec_inc[5:0];
                    if (sec_wrap)
                    begin
                        nxt.minute = min_wrap ? 6'd0 : min_inc[5:0];
                        if (min_wrap)
                        begin
                            nxt.hour = hour_wrap ? 5'd0 : hour_inc[4:0];
                            if (hour_wrap)
                            begin
                                if (day_wrap)
                                begin
                                    nxt.day = 5'd1;
                                    if (month_wrap)
                                    begin
                                        nxt.month = 4'd1;
                                        nxt.year  = cur.year + 8'd1;
                                    end
                                    else
                                    begin
                                        nxt.month = month_inc[3:0];
                                    end
                                end
                                else
                                begin
                                    nxt.day = day_inc[4:0];
                                end
                            end
                        end
                    end
                end
            end
            crt_pkg::CMD_SET_DT:
            begin
                nxt.second = set_val.second;
                nxt.minute = set_val.minute;
                nxt.hour   = set_val.hour;
                nxt.day    = set_val.day;
                nxt.month  = set_val.month;
                nxt.year   = set_val.year;
            end
            crt_pkg::CMD_SET_MS:
            begin
                nxt.millis = set_val.millis;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ----- hdl/crt_out_buf.sv -----
// Two-entry result buffer that decouples the output stream from the update stage.
module crt_out_buf #(
    parameter int WIDTH = crt_pkg::OUT_DATA_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [WIDTH-1:0] m_axis_tdata
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             pop;

    assign full          = (cnt_reg == 2'd2);
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = entry_reg[rd_ptr_reg];
    assign pop           = m_axis_tvalid && m_axis_tready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed result
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/calendar_rtc_tick_core.sv -----
// Top level of the millisecond-driven calendar clock with uptime counter.
// Each request on the slave stream (tuser = command) is registered, applied to the calendar
// state by the combinational step logic and the resulting date, time and uptime are queued as
// one result on the master stream. A new request is taken every cycle while the two-entry
// result buffer has room; each result is registered in that buffer, which drives m_axis.
// The sustained rate of one request per cycle while the buffer has room is set by the
// combinational counter carry chain between the input register and the state register.
// Command 0 ticks one millisecond, 1 loads the date and time, 2 loads the millisecond field,
// 3 leaves the state unchanged.
module calendar_rtc_tick_core #(
    parameter int TICKS_PER_SECOND = crt_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // new_second, new_minute, new_hour, new_day, new_month, new_year, new_millis, zero pad
    input  logic [crt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // cmd
    input  logic [crt_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_millis, out_second, out_minute, out_hour, out_day, out_month, out_year,
    // uptime_ticks, zero pad
    output logic [crt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    logic                in_vld_reg;
    logic [1:0]          in_cmd_reg;
    crt_pkg::set_t       in_set_reg;
    crt_pkg::set_t       in_set;
    crt_pkg::cal_state_t state_reg;
    crt_pkg::cal_state_t state_next;
    logic                ob_full;
    logic                adv;
    logic [crt_pkg::OUT_DATA_W-1:0] result_data;

    // Unpack the request payload
    assign in_set.second = s_axis_tdata[5:0];
    assign in_set.minute = s_axis_tdata[11:6];
    assign in_set.hour   = s_axis_tdata[16:12];
    assign in_set.day    = s_axis_tdata[21:17];
    assign in_set.month  = s_axis_tdata[25:22];
    assign in_set.year   = s_axis_tdata[33:26];
    assign in_set.millis = s_axis_tdata[43:34];

    assign adv           = in_vld_reg && !ob_full;
    assign s_axis_tready = !in_vld_reg || !ob_full;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg <= s_axis_tuser;
            in_set_reg <= in_set;
        end
    end

    crt_step #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_step (
        .cmd    (in_cmd_reg),
        .set_val(in_set_reg),
        .cur    (state_reg),
        .nxt    (state_next)
    );

    // Calendar state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crt_pkg::CAL_RESET;
        end
        else if (adv)
        begin
            state_reg <= state_next;
        end
    end

    // Pack the result and queue it
    assign result_data = {4'd0, state_next.uptime, state_next.year, state_next.month,
                          state_next.day, state_next.hour, state_next.minute,
                          state_next.second, state_next.millis};

    crt_out_buf #(
        .WIDTH(crt_pkg::OUT_DATA_W)
    ) u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (adv),
        .push_data    (result_data),
        .full         (ob_full),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_uptime_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_cmd_reg == crt_pkg::CMD_TICK) |=>
        (state_reg.uptime == $past(state_reg.uptime) + 32'd1))
        else $error("uptime did not advance on tick");

    a_uptime_set: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_cmd_reg != crt_pkg::CMD_TICK) |=> $stable(state_reg.uptime))
        else $error("uptime changed on non-tick request");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(state_reg))
        else $error("calendar state changed without a request");

    a_sec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_cmd_reg == crt_pkg::CMD_TICK &&
         ({1'b0, state_reg.millis} + 11'd1) < 11'(TICKS_PER_SECOND)) |=>
        $stable(state_reg.second))
        else $error("second changed without millisecond rollover");
`endif

endmodule

// ----- bench/calendar_rtc_tick_checker.sv -----
// Checker for the calendar clock core: predicts every result and compares the master stream.
`timescale 1ns / 1ps

module calendar_rtc_tick_checker #(
    parameter int TICKS_PER_SECOND = crt_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // new_second, new_minute, new_hour, new_day, new_month, new_year, new_millis, zero pad
    input  logic [crt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [crt_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_millis, out_second, out_minute, out_hour, out_day, out_month, out_year,
    // uptime_ticks, zero pad
    input  logic [crt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                             fail_count,
    output int                             pending_count
);

    crt_pkg::cal_state_t clock_now;
    crt_pkg::cal_state_t calendar_q[$];

    // Apply one request to the calendar and return the state that the result shows
    function automatic crt_pkg::cal_state_t apply_request(
        input crt_pkg::cal_state_t cur, input logic [1:0] cmd,
        input logic [crt_pkg::IN_DATA_W-1:0] data);
        crt_pkg::cal_state_t nxt;
        logic [10:0] ms_inc;
        logic [6:0]  inc;
        logic [5:0]  day_inc;
        logic [4:0]  mon_inc;
        logic [4:0]  mlen;
        logic        leap;
        int          yr;
        nxt = cur;
        yr = cur.year;
        if (cmd == crt_pkg::CMD_TICK)
        begin
            nxt.uptime = cur.uptime + 32'd1;
            ms_inc = cur.millis + 11'd1;
            if (ms_inc < TICKS_PER_SECOND)
            begin
                nxt.millis = ms_inc[9:0];
            end
            else
            begin
                nxt.millis = '0;
                inc = cur.second + 7'd1;
                if (inc < crt_pkg::SEC_PER_MIN)
                begin
                    nxt.second = inc[5:0];
                end
                else
                begin
                    nxt.second = '0;
                    inc = cur.minute + 7'd1;
                    if (inc < crt_pkg::MIN_PER_HOUR)
                    begin
                        nxt.minute = inc[5:0];
                    end
                    else
                    begin
                        nxt.minute = '0;
                        inc = cur.hour + 7'd1;
                        if (inc < crt_pkg::HOUR_PER_DAY)
                        begin
                            nxt.hour = inc[4:0];
                        end
                        else
                        begin
                            nxt.hour = '0;
                            // Leap when divisible by 4 but not by 100, or divisible by 400
                            leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
                            case (cur.month) inside
                                4'd2:                    mlen = leap ? 5'd29 : 5'd28;
                                4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
                                default:                 mlen = 5'd31;
                            endcase
                            day_inc = cur.day + 6'd1;
                            if (day_inc > mlen)
                            begin
                                nxt.day = 5'd1;
                                mon_inc = cur.month + 5'd1;
                                if (mon_inc >= crt_pkg::MONTH_WRAP)
                                begin
                                    nxt.month = 4'd1;
                                    nxt.year  = cur.year + 8'd1;
                                end
                                else
                                begin
                                    nxt.month = mon_inc[3:0];
                                end
                            end
                            else
                            begin
                                nxt.day = day_inc[4:0];
                            end
                        end
                    end
                end
            end
        end
        else if (cmd == crt_pkg::CMD_SET_DT)
        begin
            nxt.second = data[5:0];
            nxt.minute = data[11:6];
            nxt.hour   = data[16:12];
            nxt.day    = data[21:17];
            nxt.month  = data[25:22];
            nxt.year   = data[33:26];
        end
        else if (cmd == crt_pkg::CMD_SET_MS)
        begin
            nxt.millis = data[43:34];
        end
        return nxt;
    endfunction

    // Print one mismatch and count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        begin
            $display("%0d ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            fail_count = fail_count + 1;
        end
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        begin
            if (got != want)
                report_mismatch(what, got, want);
        end
    endtask

    // Track requests, predict their results and compare each result against the oldest one
    always @(posedge clk or negedge rst_n)
    begin
        crt_pkg::cal_state_t want;
        if (!rst_n)
        begin
            clock_now = crt_pkg::CAL_RESET;
            calendar_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                clock_now = apply_request(clock_now, s_axis_tuser, s_axis_tdata);
                calendar_q.push_back(clock_now);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (calendar_q.size() == 0)
                begin
                    report_mismatch("unexpected result", m_axis_tdata[9:0], -1);
                end
                else
                begin
                    want = calendar_q.pop_front();
                    check_field("out_millis",   m_axis_tdata[9:0],   want.millis);
                    check_field("out_second",   m_axis_tdata[15:10], want.second);
                    check_field("out_minute",   m_axis_tdata[21:16], want.minute);
                    check_field("out_hour",     m_axis_tdata[26:22], want.hour);
                    check_field("out_day",      m_axis_tdata[31:27], want.day);
                    check_field("out_month",    m_axis_tdata[35:32], want.month);
                    check_field("out_year",     m_axis_tdata[43:36], want.year);
                    check_field("uptime_ticks", m_axis_tdata[75:44], want.uptime);
                    check_field("tdata pad",    m_axis_tdata[79:76], 0);
                end
            end
        end
        pending_count = calendar_q.size();
    end

endmodule

// ----- bench/tb_calendar_rtc_tick_core.sv -----
// Testbench top for the calendar clock core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_calendar_rtc_tick_core;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int HOLD_CYCLES = 300;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [crt_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [crt_pkg::IN_USER_W-1:0]  s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [crt_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    int   fail_count;
    int   pending_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic rx_hold_req;

    calendar_rtc_tick_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    calendar_rtc_tick_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the handshakes hang
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Drive the result ready: random stalls, or one long hold-off when asked
    initial
    begin
        int   hold_left;
        logic hold_taken;
        hold_left     = 0;
        hold_taken    = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Pack the set fields into tdata, lowest field first
    function automatic logic [crt_pkg::IN_DATA_W-1:0] pack_fields(
        input int sec, input int min, input int hr, input int day, input int mon,
        input int yr, input int ms);
        return {4'b0, 10'(ms), 8'(yr), 4'(mon), 5'(day), 5'(hr), 6'(min), 6'(sec)};
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_request(input logic [1:0] cmd,
                                input logic [crt_pkg::IN_DATA_W-1:0] data);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid = 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid = 1'b1;
            s_axis_tuser  = cmd;
            s_axis_tdata  = data;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    // Load a date and time one millisecond before midnight, then tick across it
    task automatic roll_midnight(input int sec, input int min, input int hr, input int day,
                                 input int mon, input int yr, input int ms);
        begin
            send_request(crt_pkg::CMD_SET_DT, pack_fields(sec, min, hr, day, mon, yr, $urandom));
            send_request(crt_pkg::CMD_SET_MS, pack_fields($urandom, $urandom, $urandom,
                                                          $urandom, $urandom, $urandom, ms));
            send_request(crt_pkg::CMD_TICK, pack_fields($urandom, $urandom, $urandom, $urandom,
                                                        $urandom, $urandom, $urandom));
        end
    endtask

    // Half the time at or near the top of the range, else any bit pattern of the field or any value up to the top
    function automatic int near_top(input int top_val, input int width);
        int pick;
        pick = $urandom_range(3);
        case (pick)
            0:       return top_val;
            1:       return top_val - $urandom_range(3);
            2:       return $urandom & ((1 << width) - 1);
            default: return $urandom_range(top_val);
        endcase
    endfunction

    // One random request, weighted toward ticks and loads near the carries
    task automatic send_random();
        int          r;
        logic [1:0]  cmd;
        int          mon;
        int          yr;
        begin
            r = $urandom_range(99);
            if (r < 72)
                cmd = crt_pkg::CMD_TICK;
            else if (r < 84)
                cmd = crt_pkg::CMD_SET_DT;
            else if (r < 96)
                cmd = crt_pkg::CMD_SET_MS;
            else
                cmd = CMD_NOP;
            mon = ($urandom_range(3) == 0) ? 2 : near_top(12, 4);
            case ($urandom_range(4))
                0:       yr = 0;
                1:       yr = ($urandom_range(1) == 0) ? 100 : 200;
                2:       yr = $urandom_range(63) * 4;
                default: yr = near_top(255, 8);
            endcase
            send_request(cmd, pack_fields(near_top(59, 6), near_top(59, 6), near_top(23, 5),
                                          near_top(31, 5), mon, yr, near_top(999, 10)));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int phase;
        int n;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = crt_pkg::CMD_TICK;
        rx_hold_req   = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 67;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Reset state, a plain tick and a millisecond carry
        send_request(CMD_NOP, '1);
        send_request(crt_pkg::CMD_TICK, '0);
        send_request(crt_pkg::CMD_SET_MS, pack_fields(0, 0, 0, 0, 0, 0, 999));
        send_request(crt_pkg::CMD_TICK, '0);
        // Full carry into the next year, with the year wrapping to zero
        roll_midnight(59, 59, 23, 31, 12, 255, 999);
        // Year zero is a leap year; a century year is not
        roll_midnight(59, 59, 23, 28, 2, 0, 999);
        roll_midnight(59, 59, 23, 28, 2, 100, 999);
        // Out-of-range loads with every bit set roll over on the next tick
        roll_midnight(63, 63, 31, 31, 15, 200, 1023);
        // Day zero in month zero, and a 30-day month end
        roll_midnight(59, 59, 23, 0, 0, 7, 999);
        roll_midnight(59, 59, 23, 30, 4, 1, 999);

        // Random part in three idling phases
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 34 : 0;
            for (n = 0; n < 500; n++)
            begin
                // Stall the result side long enough to back up the input
                if (phase == 2 && n == 100)
                    rx_hold_req = 1'b1;
                // Pause the input until every result has drained
                if (phase == 2 && n == 300)
                begin
                    s_axis_tvalid = 1'b0;
                    while (pending_count != 0)
                        @(negedge clk);
                end
                send_random();
            end
        end
        s_axis_tvalid = 1'b0;

        // Drain, then wait for stray results
        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
